// ----- rtl/stk_pkg.sv -----
package stk_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 16;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    op_t               opcode;
    word_t             push_value;
    logic [POS_W-1:0]  position;
  } in_t;

  typedef struct packed {
    word_t                 data_out;
    status_t               status;
    logic [CNT_OUT_W-1:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic              push_en;
    logic              extract_en;
    logic [POS_W-1:0]  position;
  } cell_ctrl_t;

endpackage

// ----- rtl/stk_cell.sv -----
module stk_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  stk_pkg::cell_ctrl_t ctrl,
  input  stk_pkg::word_t     above,
  input  stk_pkg::word_t     below,
  output stk_pkg::word_t     data,
  output stk_pkg::word_t     rd_data
);
  import stk_pkg::*;

  localparam logic [POS_W-1:0] SLOT_POS = POS_W'(IDX + 1);

  word_t data_r;
  word_t data_nxt;
  logic  at_or_below;

  assign at_or_below = ctrl.position <= SLOT_POS;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push_en) begin
      data_nxt = above;
    end else if (ctrl.extract_en && at_or_below) begin
      data_nxt = below;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (ctrl.position == SLOT_POS) ? data_r : '0;

endmodule

// ----- rtl/stack_with_indexed_extract.sv -----
// Stack of signed 32-bit words held in a row of cells, top entry in the first
// cell. Start is accepted for every operation (push, extract at position, read
// at position, clear) whenever busy is low, and busy never rises, so a new
// transaction may follow in each cycle. The result appears on out_data with
// out_valid high for exactly the cycle after the accepting edge and must be
// taken then. All cells compare their slot with the position: a push shifts
// every cell down, an extract those at or below the position up, all in the
// same clock; the read value is an OR of the single matching cell's output.
// Positions count from 1 at the top; an extract or read outside 1..count and
// a push onto a full stack report an error and leave the stack unchanged.
module stack_with_indexed_extract #(
  parameter int DEPTH = stk_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  stk_pkg::in_t   in_data,
  output logic           out_valid,
  output stk_pkg::out_t  out_data
);
  import stk_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_t             out_r;
  out_t             out_nxt;

  word_t      cell_data [DEPTH];
  word_t      cell_rd   [DEPTH];
  word_t      rd_any;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;
  logic       pos_ok;

  assign accept = start && !busy;
  assign busy   = 1'b0;
  assign full   = count_r == CNT_W'(DEPTH);
  assign pos_ok = (in_data.position != '0) &&
                  (in_data.position <= {{(POS_W-CNT_W){1'b0}}, count_r});

  assign ctrl.push_en    = accept && (in_data.opcode == OP_PUSH) && !full;
  assign ctrl.extract_en = accept && (in_data.opcode == OP_EXTRACT) && pos_ok;
  assign ctrl.position   = in_data.position;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t above;
    word_t below;
    if (i == 0) begin : g_top
      assign above = in_data.push_value;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_data[i+1];
    end
    stk_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .above   (above),
      .below   (below),
      .data    (cell_data[i]),
      .rd_data (cell_rd[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_comb begin
    count_nxt            = count_r;
    out_nxt.data_out     = '0;
    out_nxt.status       = ST_OK;
    unique case (in_data.opcode)
      OP_PUSH: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_EXTRACT: begin
        if (pos_ok) begin
          out_nxt.data_out = rd_any;
          count_nxt        = count_r - 1'b1;
        end else begin
          out_nxt.status = ST_BAD_POS;
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          out_nxt.data_out = rd_any;
        end else begin
          out_nxt.status = ST_BAD_POS;
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
    out_nxt.entry_count = CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("transaction without result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without transaction");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> count_r == CNT_W'(DEPTH))
    else $error("full reported below depth");

  a_extract_pops: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.extract_en |=> count_r == $past(count_r) - 1'b1)
    else $error("extract did not lower the count");

endmodule

// ----- bench/stack_reply_check.sv -----
`timescale 1ns / 1ps
module stack_reply_check #(
  parameter int DEPTH = stk_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  stk_pkg::in_t  in_data,
  input  logic          out_valid,
  input  stk_pkg::out_t out_data,
  output int            fail_count,
  output int            outstanding
);
  import stk_pkg::*;

  word_t cells [DEPTH];
  int    depth_used;
  out_t  queued_replies [$];
  int    mismatches = 0;

  assign fail_count = mismatches;

  function automatic out_t apply_stack_op(input in_t op);
    out_t r;
    int   slot;
    r.data_out = '0;
    r.status   = ST_OK;
    case (op.opcode) inside
      OP_PUSH: begin
        if (depth_used >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cells[depth_used] = op.push_value;
          depth_used++;
        end
      end
      OP_EXTRACT, OP_READ: begin
        if (int'(op.position) == 0 || int'(op.position) > depth_used) begin
          r.status = ST_BAD_POS;
        end else begin
          slot       = depth_used - int'(op.position);
          r.data_out = cells[slot];
          if (op.opcode == OP_EXTRACT) begin
            for (int i = slot; i < depth_used - 1; i++) cells[i] = cells[i + 1];
            depth_used--;
          end
        end
      end
      default: begin
        depth_used = 0;
      end
    endcase
    r.entry_count = depth_used[CNT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      depth_used = 0;
      queued_replies.delete();
    end else begin
      if (out_valid) begin
        if (queued_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, %s %0d status %0d count %0d",
                   $time, "got data_out", out_data.data_out, out_data.status,
                   out_data.entry_count);
        end else begin
          want = queued_replies.pop_front();
          if (out_data.data_out !== want.data_out) begin
            mismatches++;
            $display("%0t: data_out expected %0d, got %0d",
                     $time, want.data_out, out_data.data_out);
          end
          if (out_data.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, out_data.status);
          end
          if (out_data.entry_count !== want.entry_count) begin
            mismatches++;
            $display("%0t: entry_count expected %0d, got %0d",
                     $time, want.entry_count, out_data.entry_count);
          end
        end
      end
      if (start && !busy) queued_replies.push_back(apply_stack_op(in_data));
    end
    outstanding <= queued_replies.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import stk_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 60000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic out_valid;
  in_t  in_data;
  out_t out_data;
  int   fail_count;
  int   outstanding;
  int   fill;
  int   idle_pct;
  int   cycles;

  stack_with_indexed_extract #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  stack_reply_check #(.DEPTH(DEPTH)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_t stack_cmd(input op_t code, input int pos, input word_t val);
    in_t c;
    c.opcode     = code;
    c.position   = pos[POS_W-1:0];
    c.push_value = val;
    return c;
  endfunction

  function automatic in_t random_cmd(input int push_pct);
    in_t c;
    int  pick;
    pick = $urandom_range(99);
    if (pick < push_pct) begin
      c.opcode = OP_PUSH;
    end else begin
      pick = $urandom_range(99);
      if (pick < 45) c.opcode = OP_EXTRACT;
      else if (pick < 90) c.opcode = OP_READ;
      else c.opcode = OP_CLEAR;
    end
    c.push_value = word_t'($urandom());
    case ($urandom_range(9))
      7:       c.position = ($urandom_range(1) == 0) ? '0 : POS_W'(fill + 1);
      8:       c.position = POS_W'($urandom_range(65535));
      9:       c.position = POS_W'($urandom_range(1, DEPTH + 1));
      default: c.position = POS_W'($urandom_range(1, (fill > 0) ? fill : 1));
    endcase
    return c;
  endfunction

  task automatic send_cmd(input in_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (c.opcode)
      OP_PUSH:    if (fill < DEPTH) fill++;
      OP_EXTRACT: if (c.position != 0 && int'(c.position) <= fill) fill--;
      OP_CLEAR:   fill = 0;
      default:    ;
    endcase
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int push_pct;
    int idle_sched [3];
    idle_sched = '{11, 51, 0};
    push_pct   = 50;
    fill       = 0;
    idle_pct   = idle_sched[0];
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_data    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(stack_cmd(OP_CLEAR, 0, 0));
    send_cmd(stack_cmd(OP_READ, 1, 0));
    send_cmd(stack_cmd(OP_EXTRACT, 1, 0));
    send_cmd(stack_cmd(OP_PUSH, 0, 32'sh8000_0000));
    send_cmd(stack_cmd(OP_PUSH, 65535, 32'sh7fff_ffff));
    send_cmd(stack_cmd(OP_PUSH, 0, 0));
    send_cmd(stack_cmd(OP_PUSH, 0, -1));
    send_cmd(stack_cmd(OP_READ, 0, 0));
    send_cmd(stack_cmd(OP_READ, 1, 0));
    send_cmd(stack_cmd(OP_READ, 4, 0));
    send_cmd(stack_cmd(OP_READ, 5, 0));
    send_cmd(stack_cmd(OP_READ, 65535, 0));
    send_cmd(stack_cmd(OP_EXTRACT, 65535, 0));
    send_cmd(stack_cmd(OP_EXTRACT, 0, 0));
    send_cmd(stack_cmd(OP_EXTRACT, 2, 0));
    send_cmd(stack_cmd(OP_EXTRACT, 1, 0));
    send_cmd(stack_cmd(OP_EXTRACT, 2, 0));
    send_cmd(stack_cmd(OP_READ, 1, 0));
    send_cmd(stack_cmd(OP_CLEAR, 0, 0));
    send_cmd(stack_cmd(OP_READ, 1, 0));

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = idle_sched[ph];
      repeat (DEPTH + 2) begin
        send_cmd(stack_cmd(OP_PUSH, $urandom_range(65535), word_t'($urandom())));
      end
      for (int n = 0; n < 115; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 50;
            default: push_pct = 20;
          endcase
        end
        send_cmd(random_cmd(push_pct));
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
